// ===== rtl/muon_trigger_rate_decision_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the muon trigger rate decision block
// Implication checks that are compiled only outside synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MUON_TRIGGER_RATE_DECISION_ASSERT_SVH
`define MUON_TRIGGER_RATE_DECISION_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while reset is asserted.
`define MTRD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MTRD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MTRD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MTRD_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/mtrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Muon trigger rate decision package
// Shared field widths, command codes and the structs passed between stages.
// ----------------------------------------------------------------------------
package mtrd_pkg;

    localparam int NumSources = 5;
    localparam int CmdW       = 3;
    localparam int BxW        = 3;
    localparam int QualW      = 3;
    localparam int EtaW       = 9;
    localparam int PtW        = 10;
    localparam int EtaLimW    = 8;
    localparam int PrescaleW  = 16;
    localparam int CountW     = 32;
    localparam int IndexW     = 5;

    // Candidate source codes carried in the command field.
    localparam logic [CmdW-1:0] CmdNone      = 3'd0;
    localparam logic [CmdW-1:0] CmdGlobal    = 3'd1;
    localparam logic [CmdW-1:0] CmdDriftTube = 3'd2;
    localparam logic [CmdW-1:0] CmdBarrelRpc = 3'd3;
    localparam logic [CmdW-1:0] CmdCsc       = 3'd4;
    localparam logic [CmdW-1:0] CmdFwdRpc    = 3'd5;

    // Source slots; the global source is the one with the quality cut.
    localparam int SrcGlobal = 0;

    localparam logic [QualW-1:0] MinGlobalQuality = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CfgPtThreshold = 2'd0;
    localparam logic [1:0] CfgEtaLimit    = 2'd1;
    localparam logic [1:0] CfgPrescale    = 2'd2;

    typedef struct packed {
        logic [CmdW-1:0]         cmd;
        logic signed [BxW-1:0]   bunch_crossing;
        logic [QualW-1:0]        quality;
        logic signed [EtaW-1:0]  eta;
        logic [PtW-1:0]          pt;
        logic                    event_gate;
        logic                    last_in_event;
    } t_item;

    // Per-source best values after the current item has been applied.
    typedef struct packed {
        logic [NumSources-1:0]          found;
        logic [NumSources-1:0][PtW-1:0] momentum;
    } t_best;

    typedef struct packed {
        logic                  fired;
        logic                  accepted;
        logic [CountW-1:0]     count;
        logic [NumSources-1:0] reach;
    } t_decision;

endpackage

// ===== rtl/mtrd_track.sv =====
// ----------------------------------------------------------------------------
// Muon trigger per-source candidate tracker
// Applies the candidate cuts and keeps the best passing pt of each source.
// ----------------------------------------------------------------------------
`include "muon_trigger_rate_decision_assert.svh"

module mtrd_track #(
    parameter int MAX_PER_SOURCE = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  mtrd_pkg::t_item      i_item,
    input  logic [mtrd_pkg::EtaLimW-1:0] i_eta_limit,
    output mtrd_pkg::t_best      o_best,
    output logic [$clog2(MAX_PER_SOURCE+1)-1:0] o_best_pos [mtrd_pkg::NumSources]
);

    localparam int PosW = $clog2(MAX_PER_SOURCE + 1);
    localparam int NumSrc = mtrd_pkg::NumSources;

    logic [mtrd_pkg::PtW-1:0] r_best_mom  [NumSrc];
    logic [NumSrc-1:0]        r_best_found;
    logic [PosW-1:0]          r_best_pos  [NumSrc];
    logic [PosW-1:0]          r_next_pos  [NumSrc];

    logic [mtrd_pkg::PtW-1:0] n_best_mom  [NumSrc];
    logic [NumSrc-1:0]        n_best_found;
    logic [PosW-1:0]          n_best_pos  [NumSrc];
    logic [PosW-1:0]          n_next_pos  [NumSrc];

    logic [mtrd_pkg::EtaW-1:0] w_eta_mag;
    logic                      w_common_pass;
    logic                      w_qual_ok;
    logic [NumSrc-1:0]         w_sel;
    logic [NumSrc-1:0]         w_next_ok;

    // Magnitude of a 9-bit signed eta; -256 becomes 256 and fails any limit.
    assign w_eta_mag = i_item.eta[mtrd_pkg::EtaW-1] ? (~i_item.eta + 1'b1) : i_item.eta;
    assign w_common_pass = (i_item.bunch_crossing == '0) &&
                           (w_eta_mag <= {1'b0, i_eta_limit});
    assign w_qual_ok = i_item.quality >= mtrd_pkg::MinGlobalQuality;

    always_comb begin
        w_sel = '0;
        unique case (i_item.cmd)
            mtrd_pkg::CmdGlobal:    w_sel[0] = 1'b1;
            mtrd_pkg::CmdDriftTube: w_sel[1] = 1'b1;
            mtrd_pkg::CmdBarrelRpc: w_sel[2] = 1'b1;
            mtrd_pkg::CmdCsc:       w_sel[3] = 1'b1;
            mtrd_pkg::CmdFwdRpc:    w_sel[4] = 1'b1;
            default:                w_sel = '0;
        endcase
    end

    always_comb begin
        logic hit;
        logic pass;
        logic upd;
        for (int s = 0; s < NumSrc; s++) begin
            hit  = w_sel[s] && (r_next_pos[s] < PosW'(MAX_PER_SOURCE));
            pass = hit && w_common_pass && ((s != mtrd_pkg::SrcGlobal) || w_qual_ok);
            upd  = pass && (!r_best_found[s] || (i_item.pt > r_best_mom[s]));
            n_best_found[s] = r_best_found[s] || upd;
            n_best_mom[s]   = upd ? i_item.pt : r_best_mom[s];
            n_best_pos[s]   = upd ? r_next_pos[s] : r_best_pos[s];
            n_next_pos[s]   = hit ? (r_next_pos[s] + PosW'(1)) : r_next_pos[s];
            o_best.found[s]    = n_best_found[s];
            o_best.momentum[s] = n_best_mom[s];
            o_best_pos[s]      = n_best_pos[s];
            w_next_ok[s]       = r_next_pos[s] <= PosW'(MAX_PER_SOURCE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_found <= '0;
            for (int s = 0; s < NumSrc; s++) begin
                r_best_mom[s] <= '0;
                r_best_pos[s] <= '0;
                r_next_pos[s] <= '0;
            end
        end else if (i_adv) begin
            for (int s = 0; s < NumSrc; s++) begin
                r_best_pos[s] <= n_best_pos[s];
                if (i_item.last_in_event) begin
                    r_best_mom[s] <= '0;
                    r_next_pos[s] <= '0;
                end else begin
                    r_best_mom[s] <= n_best_mom[s];
                    r_next_pos[s] <= n_next_pos[s];
                end
            end
            r_best_found <= i_item.last_in_event ? '0 : n_best_found;
        end
    end

    `MTRD_ASSERT_IMP(a_next_pos_bound, i_clk, i_rst_n, 1'b1, &w_next_ok)
    `MTRD_ASSERT_NXT(a_event_clears, i_clk, i_rst_n, i_adv && i_item.last_in_event, r_best_found == '0)

endmodule

// ===== rtl/mtrd_decide.sv =====
// ----------------------------------------------------------------------------
// Muon trigger decision and prescale
// Forms the fire decision from the best values and keeps the prescale state.
// ----------------------------------------------------------------------------
`include "muon_trigger_rate_decision_assert.svh"

module mtrd_decide (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic                              i_gate,
    input  mtrd_pkg::t_best                   i_best,
    input  logic [mtrd_pkg::PtW-1:0]          i_pt_threshold,
    input  logic [mtrd_pkg::PrescaleW-1:0]    i_prescale,
    output mtrd_pkg::t_decision               o_dec
);

    localparam int NumSrc = mtrd_pkg::NumSources;

    logic [mtrd_pkg::PrescaleW-1:0] r_phase;
    logic [mtrd_pkg::CountW-1:0]    r_total;
    logic [mtrd_pkg::PrescaleW-1:0] n_phase;
    logic [mtrd_pkg::CountW-1:0]    n_total;

    logic [NumSrc-1:0]              w_reach;
    logic                           w_fired;
    logic                           w_wrap;
    logic [mtrd_pkg::PrescaleW-1:0] w_ps;

    always_comb begin
        for (int s = 0; s < NumSrc; s++) begin
            w_reach[s] = i_gate && i_best.found[s] && (i_best.momentum[s] >= i_pt_threshold);
        end
    end

    assign w_fired = w_reach[mtrd_pkg::SrcGlobal] ||
                     (i_gate && i_best.found[mtrd_pkg::SrcGlobal] && (|w_reach[NumSrc-1:1]));

    // A prescale of zero behaves as one.
    assign w_ps   = (i_prescale == '0) ? mtrd_pkg::PrescaleW'(1) : i_prescale;
    assign w_wrap = ({1'b0, r_phase} + 17'd1) >= {1'b0, w_ps};

    always_comb begin
        n_phase = r_phase;
        n_total = r_total;
        if (w_fired) begin
            if (w_wrap) begin
                n_phase = '0;
                if (r_total != '1) begin
                    n_total = r_total + 32'd1;
                end
            end else begin
                n_phase = r_phase + 16'd1;
            end
        end
    end

    assign o_dec.fired    = w_fired;
    assign o_dec.accepted = w_fired && w_wrap;
    assign o_dec.count    = n_total;
    assign o_dec.reach    = w_reach;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_total <= '0;
        end else if (i_load) begin
            r_phase <= n_phase;
            r_total <= n_total;
        end
    end

    `MTRD_ASSERT_NXT(a_total_holds, i_clk, i_rst_n, i_load && !o_dec.accepted, r_total == $past(r_total))
    `MTRD_ASSERT_NXT(a_total_monotone, i_clk, i_rst_n, i_load, r_total >= $past(r_total))

endmodule

// ===== rtl/muon_trigger_rate_decision.sv =====
// ----------------------------------------------------------------------------
// Muon trigger rate decision
// Level-1 single muon trigger decision per event with prescaled accepts.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    contents
//  s_axis    in         s_axis_tvalid/s_axis_tready  one candidate item per beat
//  m_axis    out        m_axis_tvalid/m_axis_tready  one decision per closed event
//  cfg       in         i_cfg_valid/o_cfg_ready      register index and value
//
//  Each item is held in the input register, where the per-source compare
//  and update logic runs; a closing item loads the result register as it
//  leaves the input register, and the result register then presents the
//  event decision. One item is taken every cycle while the result
//  register is free or being drained. A stalled result holds back a closing
//  item and the items behind it; candidate items flow on while no closing
//  item waits. Reset is synchronous and active low and clears the event, prescale and count state.
//
// ----------------------------------------------------------------------------
`include "muon_trigger_rate_decision_assert.svh"

module muon_trigger_rate_decision #(
    parameter int MAX_PER_SOURCE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Candidate stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] bunch_crossing, [5:3] quality, [14:6] eta, [24:15] pt,
    // [25] event_gate, [31:26] zero
    input  logic [31:0] s_axis_tdata,
    // [2:0] cmd
    input  logic [2:0]  s_axis_tuser,
    input  logic        s_axis_tlast,

    // Decision stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] fired, [1] accepted, [33:2] accepted_count, [38:34] global_index,
    // [43:39] drift_tube_index, [48:44] barrel_rpc_index, [53:49] csc_index,
    // [58:54] forward_rpc_index, [63:59] zero
    output logic [63:0] m_axis_tdata,

    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int PosW   = $clog2(MAX_PER_SOURCE + 1);
    localparam int NumSrc = mtrd_pkg::NumSources;

    // Configuration registers.
    logic [mtrd_pkg::PtW-1:0]       r_pt_threshold;
    logic [mtrd_pkg::EtaLimW-1:0]   r_eta_limit;
    logic [mtrd_pkg::PrescaleW-1:0] r_prescale;

    // Input register holding the item being worked on.
    logic            r_in_valid;
    mtrd_pkg::t_item r_in;

    // Result register.
    logic            r_out_valid;
    logic [63:0]     r_out_data;

    logic                w_adv;
    logic                w_out_free;
    logic                w_load;
    logic                w_close_held;
    mtrd_pkg::t_best     w_best;
    logic [PosW-1:0]     w_best_pos [NumSrc];
    mtrd_pkg::t_decision w_dec;
    logic [mtrd_pkg::IndexW-1:0] w_index [NumSrc];
    logic [63:0]         n_out_data;

    // The configuration port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt_threshold <= '0;
            r_eta_limit    <= '1;
            r_prescale     <= mtrd_pkg::PrescaleW'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mtrd_pkg::CfgPtThreshold: r_pt_threshold <= i_cfg_data[mtrd_pkg::PtW-1:0];
                mtrd_pkg::CfgEtaLimit:    r_eta_limit    <= i_cfg_data[mtrd_pkg::EtaLimW-1:0];
                mtrd_pkg::CfgPrescale:    r_prescale     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The result register is free when empty or drained this cycle.
    assign w_out_free = !r_out_valid || m_axis_tready;
    // Candidate items always move on; a closing item needs room for its result.
    assign w_adv  = r_in_valid && (!r_in.last_in_event || w_out_free);
    assign w_load = w_adv && r_in.last_in_event;
    assign s_axis_tready = !r_in_valid || w_adv;

    // A closing item is waiting behind a result that is not being drained.
    assign w_close_held = r_in_valid && r_in.last_in_event && r_out_valid && !m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.cmd            <= s_axis_tuser;
            r_in.bunch_crossing <= s_axis_tdata[2:0];
            r_in.quality        <= s_axis_tdata[5:3];
            r_in.eta            <= s_axis_tdata[14:6];
            r_in.pt             <= s_axis_tdata[24:15];
            r_in.event_gate     <= s_axis_tdata[25];
            r_in.last_in_event  <= s_axis_tlast;
        end
    end

    mtrd_track #(
        .MAX_PER_SOURCE (MAX_PER_SOURCE)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_adv),
        .i_item      (r_in),
        .i_eta_limit (r_eta_limit),
        .o_best      (w_best),
        .o_best_pos  (w_best_pos)
    );

    mtrd_decide u_decide (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_load),
        .i_gate         (r_in.event_gate),
        .i_best         (w_best),
        .i_pt_threshold (r_pt_threshold),
        .i_prescale     (r_prescale),
        .o_dec          (w_dec)
    );

    // A source reports its best position, low five bits, or all ones when the
    // event gate is low, it has no passing item, or its best pt is below the threshold.
    always_comb begin
        for (int s = 0; s < NumSrc; s++) begin
            w_index[s] = w_dec.reach[s] ? mtrd_pkg::IndexW'(w_best_pos[s]) : '1;
        end
    end

    assign n_out_data = {5'b0, w_index[4], w_index[3], w_index[2], w_index[1], w_index[0],
                         w_dec.count, w_dec.accepted, w_dec.fired};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `MTRD_ASSERT_IMP(a_accept_needs_fire, i_clk, i_rst_n, r_out_valid, !r_out_data[1] || r_out_data[0])
    `MTRD_ASSERT_NXT(a_close_waits, i_clk, i_rst_n, w_close_held, r_in_valid && r_in.last_in_event)

endmodule
